// File: rtl/core/isq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared widths, operation codes and status codes of the indexed sequence
// store.
// ----------------------------------------------------------------------------
`default_nettype none

package isq_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int OP_W     = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/isq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/indexed_sequence_store_core.sv
// A rejected item goes from the check state to the response state; a get
// reads its entry in the fetch state; a delete moves each later entry down and an
// insert each entry from the position up. Each moved entry costs one read and
// one write of the single RAM. No new item is taken until the previous result
// is registered. Reset (rst_n, asynchronous, active low) empties the store; RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
// Indexed sequence store core
// Ordered list of signed values addressed by position, with insert, delete
// and get, shifting entries one at a time through a single RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_store_core
    import isq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic        [OP_W-1:0]     operation,
    input  wire logic        [POS_W-1:0]    position,
    input  wire logic signed [VALUE_W-1:0]  new_value,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic             [STATUS_W-1:0] status,
    output logic signed      [VALUE_W-1:0]  read_value,
    output logic             [COUNT_W-1:0]  entry_count
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_WR    = 7'b0010000,
        ST_PUT   = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic        [OP_W-1:0]      op_reg, op_next;
    logic        [POS_W-1:0]     pos_reg, pos_next;
    logic signed [VALUE_W-1:0]   val_reg, val_next;
    logic        [CW-1:0]        idx_reg, idx_next;
    logic        [CW-1:0]        count_reg, count_next;
    logic        [STATUS_W-1:0]  work_status_reg, work_status_next;
    logic signed [VALUE_W-1:0]   work_value_reg, work_value_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    logic        [STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic signed [VALUE_W-1:0]   rsp_value_reg, rsp_value_next;
    logic        [WIDE_W-1:0]    rsp_count_reg, rsp_count_next;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [VALUE_W-1:0] ram_rd_data;

    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] cnt_w;
    logic [WIDE_W-1:0] idx_w;
    logic [CW-1:0]     idx_dec;
    logic [CW-1:0]     idx_inc;

    assign pos_w   = WIDE_W'(pos_reg);
    assign cnt_w   = WIDE_W'(count_reg);
    assign idx_w   = WIDE_W'(idx_reg);
    assign idx_dec = idx_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;

    isq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        work_status_next = work_status_reg;
        work_value_next  = work_value_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_status_next  = rsp_status_reg;
        rsp_value_next   = rsp_value_reg;
        rsp_count_next   = rsp_count_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_addr = AW'(pos_w);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next          = operation;
                    pos_next         = position;
                    val_next         = new_value;
                    work_value_next  = '0;
                    work_status_next = STATUS_BAD_INDEX;
                    state_next       = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_RESP;
                if (op_reg == OP_INSERT)
                begin
                    if (pos_w > cnt_w)
                    begin
                        work_status_next = STATUS_BAD_INDEX;
                    end
                    else if (cnt_w >= WIDE_W'(CAPACITY))
                    begin
                        work_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        work_status_next = STATUS_OK;
                        idx_next         = count_reg;
                        state_next       = (cnt_w > pos_w) ? ST_RD : ST_PUT;
                    end
                end
                else if ((op_reg inside {OP_DELETE, OP_GET}) && pos_w < cnt_w)
                begin
                    work_status_next = STATUS_OK;
                    state_next       = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                work_value_next = $signed(ram_rd_data);
                idx_next        = CW'(pos_w);
                if (op_reg == OP_DELETE && (pos_w + 1'b1) < cnt_w)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RD:
            begin
                ram_rd_addr = (op_reg == OP_INSERT) ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
                state_next  = ST_WR;
            end
            ST_WR:
            begin
                ram_wr_en = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    idx_next   = idx_dec;
                    state_next = (WIDE_W'(idx_dec) > pos_w) ? ST_RD : ST_PUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ((idx_w + WIDE_W'(2)) < cnt_w) ? ST_RD : ST_RESP;
                end
            end
            ST_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(pos_w);
                ram_wr_data = val_reg;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (work_status_reg == STATUS_OK && op_reg == OP_INSERT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (work_status_reg == STATUS_OK && op_reg == OP_DELETE)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = work_status_reg;
                    rsp_value_next  = work_value_reg;
                    rsp_count_next  = WIDE_W'(count_next);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        work_status_reg <= work_status_next;
        work_value_reg  <= work_value_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_value_reg   <= rsp_value_next;
        rsp_count_reg   <= rsp_count_next;
    end

    assign req_stall   = (state_reg != ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign read_value  = rsp_value_reg;
    assign entry_count = rsp_count_reg[COUNT_W-1:0];

endmodule

`default_nettype wire
